FILE: rtl/pbrr_pkg.sv
`default_nettype none
package pbrr_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int COUNT_BITS = 14;

  localparam int BR_W      = FRAC_BITS + 1;
  localparam int AR_W      = FRAC_BITS + 2;
  localparam int FRAME_W   = 4;
  localparam int MAXP_W    = 14;
  localparam int HARD_W    = 14;
  localparam int UMULT_W   = 16;
  localparam int DMULT_W   = 15;
  localparam int CFG_W     = 16;
  localparam int IDX_W     = 8;
  localparam int MULT_FRAC = 14;
  localparam int MB_W      = MAXP_W + 3;
  localparam int PROD_W    = AR_W + MB_W;
  localparam int DEN_W     = COUNT_BITS + 4;
  localparam int CNT_W     = $clog2(PROD_W);
  localparam int MULB_W    = BR_W;
  localparam int MPROD_W   = AR_W + MULB_W;
  localparam int RECIP_SH  = FRAC_BITS + 4;

  localparam longint ONE_L   = longint'(1) << FRAC_BITS;
  localparam longint NUDGE_L = (ONE_L * 125 + 50000) / 100000;
  localparam longint TINY_RL = (ONE_L + 5000000) / 10000000;
  localparam longint TINY_L  = (TINY_RL != 0) ? TINY_RL : 1;
  localparam longint RECIP_L = ((longint'(1) << RECIP_SH) + 9) / 10;

  localparam logic [BR_W-1:0] ONE_Q      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [BR_W-1:0] NUDGE_Q    = BR_W'(NUDGE_L);
  localparam logic [BR_W-1:0] TINY_Q     = BR_W'(TINY_L);
  localparam logic [BR_W-1:0] ONE_TENTH  = BR_W'(ONE_L / 10);
  localparam logic [AR_W-1:0] ADAPT_MAX  = {AR_W{1'b1}};
  localparam logic [AR_W-1:0] ADAPT_TWO  = AR_W'(ONE_L * 2);
  localparam logic [AR_W-1:0] ADAPT_LOW  = AR_W'(ONE_L / 32);
  localparam logic [AR_W-1:0] BURST_RST  = AR_W'(ONE_L / 2);
  localparam logic [AR_W-1:0] ADAPT_RST  = AR_W'(ONE_L / 16);
  localparam logic [MULB_W-1:0] RECIP_TEN = MULB_W'(RECIP_L);

  localparam logic [MAXP_W-1:0]  MAXP_MIN  = MAXP_W'(2);
  localparam logic [MAXP_W-1:0]  MAXP_MAX  = MAXP_W'(8192);
  localparam logic [MAXP_W-1:0]  MAXP_RST  = MAXP_W'(4096);
  localparam logic [HARD_W-1:0]  HARD_RST  = HARD_W'(8192);
  localparam logic [UMULT_W-1:0] UMULT_RST = UMULT_W'(18022);
  localparam logic [DMULT_W-1:0] DMULT_RST = DMULT_W'(14895);

  localparam logic [IDX_W-1:0] REG_MAX_PARTICLES   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_HARD_LIMIT      = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ADAPT_UP_MULT   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_ADAPT_DOWN_MULT = IDX_W'(3);

  typedef struct packed {
    logic [FRAME_W-1:0]    frame_low;
    logic [COUNT_BITS-1:0] particle_count;
  } in_req_t;

  typedef struct packed {
    logic [BR_W-1:0] burst_rate_out;
    logic [AR_W-1:0] adaptive_rate_out;
    logic            updated;
  } out_req_t;

endpackage
`default_nettype wire

FILE: rtl/particle_burst_rate_regulator.sv
`default_nettype none
// Frame-tick rate regulator. Each request carries the low frame bits and the
// live particle count and returns one result with the burst rate (Q1.24) and
// the adaptive rate (Q2.24); on frames whose low bits are zero both rates are
// updated first and the result has updated set. One request is in work at a
// time and the block is not ready meanwhile. A frame without update goes from
// acceptance straight to the output step. An update frame scales the adaptive
// rate and then goes to the output step when the burst rate is set directly
// (count at the hard limit, zero count, tiny rate); otherwise it runs one 43-step
// restoring divider for the burst ratio; one 26x25 multiplier is shared by the
// adaptive scaling, the ratio numerator and the tenth of the larger rate
// (reciprocal multiply). While the output register still holds an untaken
// result, a finished request waits in its last step. Configuration writes are
// taken at once; the user is to make them only while the block is idle (not enforced).
module particle_burst_rate_regulator (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pbrr_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pbrr_pkg::out_req_t     out_data,
  input  wire logic                          cfg_we,
  input  wire logic [pbrr_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [pbrr_pkg::CFG_W-1:0]    cfg_wdata
);
  import pbrr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_MUL_A  = 10'b00_0000_0010,
    S_ADAPT  = 10'b00_0000_0100,
    S_MUL_B  = 10'b00_0000_1000,
    S_LOAD_Q = 10'b00_0001_0000,
    S_DIV_Q  = 10'b00_0010_0000,
    S_LOAD_T = 10'b00_0100_0000,
    S_MUL_T  = 10'b00_1000_0000,
    S_APPLY  = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [MAXP_W-1:0]    max_r;
  logic [HARD_W-1:0]    hard_r;
  logic [UMULT_W-1:0]   umult_r;
  logic [DMULT_W-1:0]   dmult_r;
  logic [BR_W-1:0]      burst_r, burst_nxt;
  logic [AR_W-1:0]      adapt_r, adapt_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic                 upd_r;
  logic [MPROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]    quo_r, quo_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [CNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic [BR_W-1:0]      nr_r, nr_nxt;
  logic                 out_valid_r;
  out_req_t             out_data_r;

  logic [MAXP_W-1:0]    cfg_maxp;
  logic [AR_W-1:0]      mul_a;
  logic [MULB_W-1:0]    mul_b;
  logic [MB_W-1:0]      max9;
  logic [DEN_W-1:0]     count10;
  logic [MB_W+1:0]      cnt8, max7, cnt2;
  logic                 up_c, dn_c;
  logic [MPROD_W:0]     rnd;
  logic [MPROD_W:0]     adapt_p;
  logic [DEN_W:0]       shifted, trial;
  logic [BR_W:0]        nudge_sum;
  logic [BR_W-1:0]      nr_c, big, th0, th;
  logic signed [BR_W+1:0] d, th_s, dc, half;
  logic signed [BR_W+2:0] r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cfg_maxp = cfg_wdata[MAXP_W-1:0];
    if (cfg_maxp < MAXP_MIN) begin
      cfg_maxp = MAXP_MIN;
    end else if (cfg_maxp > MAXP_MAX) begin
      cfg_maxp = MAXP_MAX;
    end
  end

  assign max9    = (MB_W'(max_r) << 3) + MB_W'(max_r);
  assign count10 = (DEN_W'(count_r) << 3) + (DEN_W'(count_r) << 1);
  assign cnt8    = (MB_W+2)'(count_r) << 3;
  assign cnt2    = (MB_W+2)'(count_r) << 1;
  assign max7    = ((MB_W+2)'(max_r) << 3) - (MB_W+2)'(max_r);
  assign up_c    = (cnt8 > max7) && (adapt_r < ADAPT_TWO);
  assign dn_c    = (cnt2 < (MB_W+2)'(max_r)) && (adapt_r > ADAPT_LOW);

  always_comb begin
    if (state_r == S_MUL_B) begin
      mul_a = AR_W'(burst_r);
      mul_b = MULB_W'(max9);
    end else if (state_r == S_MUL_T) begin
      mul_a = AR_W'(big);
      mul_b = RECIP_TEN;
    end else if (up_c) begin
      mul_a = adapt_r;
      mul_b = MULB_W'(umult_r);
    end else begin
      mul_a = adapt_r;
      mul_b = MULB_W'(dmult_r);
    end
  end

  assign rnd     = {1'b0, prod_r} + (MPROD_W+1)'(1 << (MULT_FRAC - 1));
  assign adapt_p = rnd >> MULT_FRAC;

  assign shifted = {rem_r, quo_r[PROD_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  assign nudge_sum = {1'b0, burst_r} + {1'b0, NUDGE_Q};
  assign nr_c      = (quo_r > PROD_W'(ONE_Q)) ? ONE_Q : quo_r[BR_W-1:0];
  assign big       = (nr_r > burst_r) ? nr_r : burst_r;
  assign th0       = BR_W'(prod_r >> RECIP_SH);
  assign th        = (th0 > ONE_TENTH) ? ONE_TENTH : th0;
  assign th_s      = $signed({2'b00, th});
  assign d         = $signed({2'b00, nr_r}) - $signed({2'b00, burst_r});

  always_comb begin
    if (d > th_s) begin
      dc = th_s;
    end else if (d < -th_s) begin
      dc = -th_s;
    end else begin
      dc = d;
    end
    half = (dc + $signed((BR_W+2)'(dc[BR_W+1]))) >>> 1;
    r    = $signed({3'b000, burst_r}) + $signed({half[BR_W+1], half});
  end

  always_comb begin
    state_nxt = state_r;
    burst_nxt = burst_r;
    adapt_nxt = adapt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    dcnt_nxt  = dcnt_r;
    nr_nxt    = nr_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.frame_low == '0) ? S_MUL_A : S_OUT;
        end
      end
      S_MUL_A: begin
        state_nxt = S_ADAPT;
      end
      S_ADAPT: begin
        if (up_c || dn_c) begin
          adapt_nxt = (adapt_p > (MPROD_W+1)'(ADAPT_MAX)) ? ADAPT_MAX : adapt_p[AR_W-1:0];
        end
        state_nxt = S_OUT;
        if (count_r >= COUNT_BITS'(hard_r)) begin
          burst_nxt = '0;
        end else if (count_r == '0) begin
          burst_nxt = (nudge_sum > {1'b0, ONE_Q}) ? ONE_Q : nudge_sum[BR_W-1:0];
        end else if (burst_r <= TINY_Q) begin
          burst_nxt = burst_r + TINY_Q;
        end else begin
          state_nxt = S_MUL_B;
        end
      end
      S_MUL_B: begin
        state_nxt = S_LOAD_Q;
      end
      S_LOAD_Q: begin
        quo_nxt   = prod_r[PROD_W-1:0];
        rem_nxt   = '0;
        den_nxt   = count10;
        dcnt_nxt  = '0;
        state_nxt = S_DIV_Q;
      end
      S_DIV_Q: begin
        quo_nxt = {quo_r[PROD_W-2:0], ~trial[DEN_W]};
        rem_nxt = trial[DEN_W] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
        dcnt_nxt = dcnt_r + CNT_W'(1);
        if (dcnt_r == CNT_W'(PROD_W - 1)) begin
          state_nxt = S_LOAD_T;
        end
      end
      S_LOAD_T: begin
        nr_nxt    = nr_c;
        state_nxt = S_MUL_T;
      end
      S_MUL_T: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (r < 0) begin
          burst_nxt = '0;
        end else if (r > $signed({3'b000, ONE_Q})) begin
          burst_nxt = ONE_Q;
        end else begin
          burst_nxt = r[BR_W-1:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= MAXP_RST;
      hard_r      <= HARD_RST;
      umult_r     <= UMULT_RST;
      dmult_r     <= DMULT_RST;
      burst_r     <= BURST_RST[BR_W-1:0];
      adapt_r     <= ADAPT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      burst_r <= burst_nxt;
      adapt_r <= adapt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_PARTICLES:   max_r   <= cfg_maxp;
          REG_HARD_LIMIT:      hard_r  <= cfg_wdata[HARD_W-1:0];
          REG_ADAPT_UP_MULT:   umult_r <= cfg_wdata[UMULT_W-1:0];
          REG_ADAPT_DOWN_MULT: dmult_r <= cfg_wdata[DMULT_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    dcnt_r <= dcnt_nxt;
    nr_r   <= nr_nxt;
    if (state_r == S_IDLE && in_valid) begin
      count_r <= in_data.particle_count;
      upd_r   <= (in_data.frame_low == '0);
    end
    if (state_r == S_MUL_A || state_r == S_MUL_B || state_r == S_MUL_T) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_data_r.burst_rate_out    <= burst_r;
      out_data_r.adaptive_rate_out <= adapt_r;
      out_data_r.updated           <= upd_r;
    end
  end

  a_burst_range: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r <= ONE_Q)
    else $error("burst rate above one");

  a_maxp_range: assert property (@(posedge clk) disable iff (!rst_n)
    max_r >= MAXP_MIN && max_r <= MAXP_MAX)
    else $error("particle budget out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_Q) |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbrr_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 8;
  localparam int FRAMES_PER_PHASE = 250;

  class rate_scoreboard;
    int unsigned errors;
    out_req_t    rates_q[$];
    longint      max_p;
    longint      hard_lim;
    longint      up_mult;
    longint      down_mult;
    longint      burst;
    longint      adaptive;

    function new();
      errors    = 0;
      max_p     = longint'(MAXP_RST);
      hard_lim  = longint'(HARD_RST);
      up_mult   = longint'(UMULT_RST);
      down_mult = longint'(DMULT_RST);
      burst     = ONE_L / 2;
      adaptive  = ONE_L / 16;
    endfunction

    function int pending();
      return rates_q.size();
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      longint v;
      case (idx)
        REG_MAX_PARTICLES: begin
          v = longint'(data[MAXP_W-1:0]);
          if (v < longint'(MAXP_MIN)) v = longint'(MAXP_MIN);
          if (v > longint'(MAXP_MAX)) v = longint'(MAXP_MAX);
          max_p = v;
        end
        REG_HARD_LIMIT:      hard_lim  = longint'(data[HARD_W-1:0]);
        REG_ADAPT_UP_MULT:   up_mult   = longint'(data[UMULT_W-1:0]);
        REG_ADAPT_DOWN_MULT: down_mult = longint'(data[DMULT_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint scale_q14(longint a, longint m);
      longint p;
      p = (a * m + (longint'(1) << (MULT_FRAC - 1))) >> MULT_FRAC;
      if (p > longint'(ADAPT_MAX)) p = longint'(ADAPT_MAX);
      return p;
    endfunction

    function void note_request(in_req_t req);
      longint   count;
      longint   ratio;
      longint   larger;
      longint   th;
      longint   delta;
      longint   nxt;
      logic     upd;
      out_req_t rates;
      count = longint'(req.particle_count);
      upd   = (req.frame_low == '0);
      if (upd) begin
        if (count * 8 > max_p * 7 && adaptive < 2 * ONE_L) begin
          adaptive = scale_q14(adaptive, up_mult);
        end else if (count * 2 < max_p && adaptive > ONE_L / 32) begin
          adaptive = scale_q14(adaptive, down_mult);
        end
        if (count >= hard_lim) begin
          burst = 0;
        end else if (count == 0) begin
          burst = burst + NUDGE_L;
          if (burst > ONE_L) burst = ONE_L;
        end else if (burst <= TINY_L) begin
          burst = burst + TINY_L;
        end else begin
          ratio = (9 * max_p * burst) / (10 * count);
          if (ratio > ONE_L) ratio = ONE_L;
          larger = (ratio > burst) ? ratio : burst;
          th = larger / 10;
          if (th > ONE_L / 10) th = ONE_L / 10;
          delta = ratio - burst;
          if (delta > th) delta = th;
          if (delta < -th) delta = -th;
          nxt = burst + delta / 2;
          if (nxt < 0) nxt = 0;
          if (nxt > ONE_L) nxt = ONE_L;
          burst = nxt;
        end
      end
      rates.burst_rate_out    = burst[BR_W-1:0];
      rates.adaptive_rate_out = adaptive[AR_W-1:0];
      rates.updated           = upd;
      rates_q.insert(rates_q.size(), rates);
    endfunction

    task report(string msg);
      if (errors < 200) $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_req_t got);
      out_req_t want;
      if (rates_q.size() == 0) begin
        report($sformatf("result with nothing pending: burst %h adaptive %h updated %b",
                         got.burst_rate_out, got.adaptive_rate_out, got.updated));
        return;
      end
      want = rates_q.pop_front();
      if (got.burst_rate_out !== want.burst_rate_out)
        report($sformatf("burst_rate_out %h, want %h",
                         got.burst_rate_out, want.burst_rate_out));
      if (got.adaptive_rate_out !== want.adaptive_rate_out)
        report($sformatf("adaptive_rate_out %h, want %h",
                         got.adaptive_rate_out, want.adaptive_rate_out));
      if (got.updated !== want.updated)
        report($sformatf("updated %b, want %b", got.updated, want.updated));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_req_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_req_t          out_data;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  bit                steady = 1'b0;
  int unsigned       quiet_cycles = 0;
  rate_scoreboard    sb;

  particle_burst_rate_regulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_frame(input logic [FRAME_W-1:0] frame, input logic [COUNT_BITS-1:0] count);
    in_req_t req;
    req.frame_low      = frame;
    req.particle_count = count;
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic configure(input int phase);
    logic [CFG_W-1:0] maxp;
    logic [CFG_W-1:0] hard;
    logic [CFG_W-1:0] up;
    logic [CFG_W-1:0] down;
    wait_drained();
    repeat (8) @(posedge clk);
    case (phase)
      1: begin
        maxp = 16'd8192; hard = 16'd16383; up = 16'd65535; down = 16'd16384;
      end
      2: begin
        maxp = 16'd0; hard = 16'd1; up = 16'd16384; down = 16'd0;
      end
      3: begin
        maxp = 16'hFFFF; hard = 16'hFFFF; up = 16'hFFFF; down = 16'hFFFF;
      end
      4: begin
        maxp = 16'd2; hard = 16'd3;
        up = 16'($urandom_range(16384, 65535)); down = 16'($urandom_range(0, 16384));
      end
      default: begin
        maxp = 16'($urandom_range(2, 8192));
        hard = 16'($urandom_range(1, 16383));
        up   = 16'($urandom_range(16384, 65535));
        down = 16'($urandom_range(0, 16384));
        if ($urandom_range(3) == 0) maxp = 16'($urandom);
        if ($urandom_range(3) == 0) down = 16'($urandom);
      end
    endcase
    write_reg(REG_MAX_PARTICLES, maxp);
    write_reg(REG_HARD_LIMIT, hard);
    write_reg(REG_ADAPT_UP_MULT, up);
    write_reg(REG_ADAPT_DOWN_MULT, down);
    if (phase == 1 || phase > 4) write_reg(IDX_W'($urandom_range(4, 255)), 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COUNT_BITS-1:0] pick_count();
    int sel;
    int c;
    sel = $urandom_range(99);
    if (sel < 10)      c = 0;
    else if (sel < 25) c = int'(sb.hard_lim) + $urandom_range(4) - 2;
    else if (sel < 45) c = int'(sb.max_p * 7 / 8) + $urandom_range(6) - 3;
    else if (sel < 65) c = int'(sb.max_p / 2) + $urandom_range(6) - 3;
    else if (sel < 85) c = $urandom_range(1, 2 * int'(sb.max_p));
    else               c = $urandom_range(16383);
    if (c < 0) c = 0;
    if (c > 16383) c = 16383;
    return COUNT_BITS'(c);
  endfunction

  initial begin
    logic [FRAME_W-1:0] frame;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_frame(4'd5, 14'd100);
    send_frame(4'd15, 14'd16383);
    send_frame(4'd0, 14'd0);
    send_frame(4'd0, 14'd4096);
    send_frame(4'd0, 14'd3584);
    send_frame(4'd0, 14'd3585);
    send_frame(4'd0, 14'd2047);
    send_frame(4'd0, 14'd2048);
    send_frame(4'd0, 14'd1);
    send_frame(4'd0, 14'd1);
    send_frame(4'd0, 14'd16383);
    send_frame(4'd0, 14'd8191);
    send_frame(4'd0, 14'd8191);
    send_frame(4'd0, 14'd8191);
    send_frame(4'd0, 14'd8192);
    send_frame(4'd0, 14'd1);
    send_frame(4'd0, 14'd1);
    send_frame(4'd0, 14'd1);
    send_frame(4'd0, 14'd0);
    send_frame(4'd7, 14'd0);
    send_frame(4'd0, 14'd9000);
    send_frame(4'd10, 14'd10922);
    send_frame(4'd0, 14'd5461);

    for (int phase = 1; phase <= PHASES; phase++) begin
      configure(phase);
      steady = (phase == 3);
      for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
        frame = ($urandom_range(99) < 45) ? '0 : FRAME_W'($urandom_range(15));
        send_frame(frame, pick_count());
      end
    end

    wait_drained();
    repeat (120) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
